// File: rtl/uudecode_line_stream_assert.svh
// Assertion macros shared by the uudecode line stream modules.
`ifndef UUDECODE_LINE_STREAM_ASSERT_SVH
`define UUDECODE_LINE_STREAM_ASSERT_SVH

`ifndef SYNTHESIS
// Check prop on every clock edge outside reset.
`define ULS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("uudecode line stream assertion failed");
// Check that cons holds in the cycle after ante.
`define ULS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uudecode line stream assertion failed");
`else
`define ULS_ASSERT(lbl, clk, rst_n, prop)
`define ULS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/uls_pkg.sv
package uls_pkg;

  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharBackquote = 8'h60;
  localparam logic [7:0] CharTilde     = 8'h7e;

  // Entries in the character queue between front and back.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    RC_DATA  = 2'd0,
    RC_END   = 2'd1,
    RC_SHORT = 2'd2
  } result_code_e;

  // Position within a line: count character, then the four characters of a group.
  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_G1    = 3'd1,
    PH_G2    = 3'd2,
    PH_G3    = 3'd3,
    PH_G4    = 3'd4
  } phase_e;

  typedef struct packed {
    logic [5:0] sextet;
    logic       line_end;
  } char_t;

  // Head of the character queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    char_t chr;
  } chr_req_t;

  function automatic logic [5:0] to_sextet(input logic [7:0] symbol);
    logic [7:0] c;
    c = symbol;
    if (c == CharBackquote || c == CharTilde) begin
      c = CharSpace;
    end
    return 6'(c - CharSpace);
  endfunction

endpackage

// File: rtl/uls_front.sv
`include "uudecode_line_stream_assert.svh"

module uls_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         symbol_i,
  input  logic               line_end_i,
  output uls_pkg::chr_req_t  head_o,
  input  logic               pop_i
);

  uls_pkg::char_t mem_q [uls_pkg::QueueDepth];
  logic [1:0]     count_q, count_d;
  logic           wr_q, rd_q;
  logic           push;

  assign in_ready_o = (count_q != 2'(uls_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;

  // Map to a sextet on the way in; the back end only sees six-bit values.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{sextet: uls_pkg::to_sextet(symbol_i), line_end: line_end_i};
    end
  end

  always_comb begin
    count_d = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.chr   = mem_q[rd_q];

  `ULS_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(pop_i && count_q == 2'd0))
  `ULS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= 2'(uls_pkg::QueueDepth))

endmodule

// File: rtl/uls_back.sv
`include "uudecode_line_stream_assert.svh"

module uls_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uls_pkg::chr_req_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        data_byte_o,
  output logic [1:0]        result_code_o
);

  uls_pkg::phase_e       phase_q, phase_d;
  logic [5:0]            rem_q, rem_d;
  logic [5:0]            prev_q, prev_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            byte_q, byte_d;
  uls_pkg::result_code_e code_q, code_d;

  logic [5:0]            s;
  logic                  last;
  logic                  have_res;
  logic                  have_byte;
  logic [7:0]            res_byte;
  uls_pkg::result_code_e res_code;
  logic [5:0]            rem_n;

  assign s     = head_i.chr.sextet;
  assign last  = head_i.chr.line_end;
  assign pop_o = head_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    prev_d    = prev_q;
    have_res  = 1'b0;
    have_byte = 1'b0;
    res_byte  = '0;
    res_code  = uls_pkg::RC_DATA;
    rem_n     = rem_q;

    case (phase_q)
      uls_pkg::PH_G1: begin
        phase_d = uls_pkg::PH_G2;
      end
      uls_pkg::PH_G2: begin
        res_byte  = {prev_q, s[5:4]};
        have_byte = 1'b1;
        phase_d   = uls_pkg::PH_G3;
      end
      uls_pkg::PH_G3: begin
        res_byte  = {prev_q[3:0], s[5:2]};
        have_byte = 1'b1;
        phase_d   = uls_pkg::PH_G4;
      end
      uls_pkg::PH_G4: begin
        res_byte  = {prev_q[1:0], s};
        have_byte = 1'b1;
        phase_d   = uls_pkg::PH_G1;
      end
      default: begin
        // Count character.
        rem_d   = s;
        phase_d = uls_pkg::PH_G1;
        if (last) begin
          have_res = 1'b1;
          res_code = (s == 6'd0) ? uls_pkg::RC_END : uls_pkg::RC_SHORT;
          phase_d  = uls_pkg::PH_COUNT;
          rem_d    = '0;
          prev_d   = '0;
        end
      end
    endcase

    if (phase_q inside {uls_pkg::PH_G1, uls_pkg::PH_G2, uls_pkg::PH_G3, uls_pkg::PH_G4}) begin
      prev_d = s;
      // Drop bytes beyond the line's count.
      if (have_byte && rem_q != 6'd0) begin
        rem_n = rem_q - 6'd1;
      end else begin
        have_byte = 1'b0;
      end
      rem_d    = rem_n;
      have_res = have_byte;
      if (last) begin
        phase_d = uls_pkg::PH_COUNT;
        rem_d   = '0;
        prev_d  = '0;
        if (rem_n != 6'd0) begin
          have_res = 1'b1;
          res_code = uls_pkg::RC_SHORT;
          res_byte = '0;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    code_d      = code_q;
    if (pop_o) begin
      out_valid_d = have_res;
      byte_d      = res_byte;
      code_d      = res_code;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= uls_pkg::PH_COUNT;
      rem_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        rem_q   <= rem_d;
        prev_q  <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    code_q <= code_d;
  end

  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = byte_q;
  assign result_code_o = code_q;

  `ULS_ASSERT_NEXT(a_line_end_restart, clk_i, rst_ni, pop_o && last,
                   phase_q == uls_pkg::PH_COUNT && rem_q == 6'd0)
  `ULS_ASSERT(a_count_phase_clear, clk_i, rst_ni,
              phase_q != uls_pkg::PH_COUNT || rem_q == 6'd0)
  `ULS_ASSERT(a_no_pop_when_blocked, clk_i, rst_ni,
              !(pop_o && out_valid_q && !out_ready_i))

endmodule

// File: rtl/uudecode_line_stream.sv
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_ready_o  symbol_i[7:0], line_end_i
// output    out        out_valid_o / out_ready_i data_byte_o[7:0], result_code_o[1:0]
//
// One character per cycle sustained while the output is not stalled; each character
// is held in the character queue, and its result is then held in the output register.
// The two-entry queue lies between front and back; the back end
// decodes one character per cycle whenever its output register is free or drained.
// rst_ni clears the queue, the line state and the output valid at once.
// A stalled output holds the back end; the queue then fills and drops in_ready_o.

module uudecode_line_stream (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [1:0] result_code_o
);

  // Head of the character queue and the back end's pop.
  uls_pkg::chr_req_t head;
  logic              pop;

  // Front: map each character to its sextet and hold it in the queue.
  uls_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .symbol_i   (symbol_i),
    .line_end_i (line_end_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back: track line position and count, assemble bytes, report end and short lines.
  uls_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .result_code_o (result_code_o)
  );

endmodule
